// ===== rtl/mrr_pkg.sv =====
// Shared definitions for the matrix ring rotator: widths, register indexes,
// controller states and the command/status words between controller and datapath.
// Depends on nothing.
package mrr_pkg;

    // Matrix geometry and word widths
    localparam int MAX_DIM     = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int POS_W       = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 7;
    localparam int STEP_W      = 20;
    localparam int RING_W      = IDX_W + 3;
    localparam int LEN_W       = IDX_W + 2;
    localparam int SUM_W       = STEP_W + 1;

    // Divider: bits retired per cycle and cycles per division
    localparam int DIV_STEPS   = 3;
    localparam int DIV_CYCLES  = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = STEP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_STEPS = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_POS,
        ST_RING,
        ST_MOD_GO,
        ST_DIV_MOD,
        ST_ADDR,
        ST_MEM,
        ST_OUT
    } mrr_state_t;

    typedef struct packed {
        logic load_we;
        logic read_start;
        logic ring_latch;
        logic mod_start;
        logic addr_latch;
        logic mem_rd;
        logic out_load;
    } mrr_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } mrr_status_t;

endpackage

// ===== rtl/mrr_divider.sv =====
// Multi-cycle restoring divider, DIV_STEPS quotient bits per clock.
// Shared by the raster split (position / cols) and the ring modulo.
// Depends on mrr_pkg.
module mrr_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mrr_pkg::SUM_W-1:0] dividend,
    input  logic [mrr_pkg::LEN_W-1:0] divisor,
    output logic                      busy,
    output logic [mrr_pkg::SUM_W-1:0] quotient,
    output logic [mrr_pkg::LEN_W-1:0] remainder
);
    import mrr_pkg::*;

    logic [SUM_W-1:0]     quo_reg;
    logic [SUM_W-1:0]     quo_next;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     rem_next;
    logic [LEN_W-1:0]     div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [LEN_W:0]       shifted;
    logic                 ge;

    // Retire DIV_STEPS quotient bits
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        shifted  = '0;
        ge       = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            shifted  = {rem_next, quo_next[SUM_W-1]};
            ge       = (shifted >= {1'b0, div_reg});
            quo_next = {quo_next[SUM_W-2:0], ge};
            rem_next = ge ? LEN_W'(shifted - {1'b0, div_reg}) : shifted[LEN_W-1:0];
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Count division cycles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/mrr_datapath.sv =====
// Datapath of the matrix ring rotator: configuration registers, position
// counters, ring geometry, shared divider, matrix store and output register.
// Depends on mrr_pkg and mrr_divider.
module mrr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mrr_pkg::mrr_cmd_t              cmd,
    output mrr_pkg::mrr_status_t           status,
    input  logic                           cfg_we,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [mrr_pkg::DATA_WIDTH-1:0] element_value,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic signed [mrr_pkg::DATA_WIDTH-1:0] rotated_value,
    output logic                           row_end,
    output logic                           matrix_end
);
    import mrr_pkg::*;

    // Configuration
    logic [DIM_W-1:0]  row_count_reg;
    logic [DIM_W-1:0]  col_count_reg;
    logic [STEP_W-1:0] rotate_steps_reg;

    logic [DIM_W-1:0]  n_eff;
    logic [DIM_W-1:0]  m_eff;
    logic [POS_W:0]    total;

    // Position counters
    logic [POS_W-1:0]  load_pos_reg;
    logic [POS_W-1:0]  load_pos_next;
    logic [POS_W-1:0]  load_eff;
    logic [POS_W:0]    load_inc;
    logic [POS_W-1:0]  read_pos_reg;
    logic [POS_W-1:0]  read_pos_next;
    logic [POS_W-1:0]  read_eff;
    logic [POS_W:0]    read_inc;
    logic [POS_W-1:0]  rpos_reg;

    // Ring geometry
    logic [RING_W-1:0] i_v, j_v, n_v, m_v;
    logic [RING_W-1:0] ri_v, cj_v, k_v, w_v, h_v, len_v, b1_v, b2_v, p_v, half_v;
    logic              in_ring_v;
    logic [RING_W-1:0] k_reg, w_reg, b1_reg, b2_reg, p_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              in_ring_reg;
    logic              row_end_reg;
    logic              mat_end_reg;

    // Source address
    logic [RING_W-1:0] q_v, sr_v, sc_v, last_r_v, last_c_v;
    logic [POS_W:0]    src_prod;
    logic [POS_W-1:0]  addr_next;
    logic [POS_W-1:0]  addr_reg;

    // Divider hookup
    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic [LEN_W-1:0]  div_divisor;
    logic              div_busy;
    logic [SUM_W-1:0]  div_quo;
    logic [LEN_W-1:0]  div_rem;

    // Store and output
    logic [DATA_WIDTH-1:0] store_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] rot_reg;
    logic                  row_end_out_reg;
    logic                  mat_end_out_reg;
    logic                  out_valid_reg;
    logic                  out_take;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v < DIM_W'(2))
            begin
                r = DIM_W'(2);
            end
            else if (v > DIM_W'(MAX_DIM))
            begin
                r = DIM_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_W'(2);
            col_count_reg    <= DIM_W'(2);
            rotate_steps_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data[DIM_W-1:0];
                CFG_COL_COUNT:    col_count_reg    <= cfg_data[DIM_W-1:0];
                CFG_ROTATE_STEPS: rotate_steps_reg <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    assign n_eff = clamp_dim(row_count_reg);
    assign m_eff = clamp_dim(col_count_reg);
    assign total = (POS_W+1)'(n_eff * m_eff);

    // Advance load and read counters, wrapping at the matrix end
    always_comb
    begin
        load_eff      = ({1'b0, load_pos_reg} < total) ? load_pos_reg : '0;
        load_inc      = {1'b0, load_eff} + 1'b1;
        load_pos_next = (load_inc == total) ? '0 : load_inc[POS_W-1:0];
        read_eff      = ({1'b0, read_pos_reg} < total) ? read_pos_reg : '0;
        read_inc      = {1'b0, read_eff} + 1'b1;
        read_pos_next = (read_inc == total) ? '0 : read_inc[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            read_pos_reg <= '0;
        end
        else
        begin
            if (cmd.load_we)
            begin
                load_pos_reg <= load_pos_next;
            end
            if (cmd.read_start)
            begin
                read_pos_reg <= read_pos_next;
            end
        end
    end

    // Write the store on loads
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            store_mem[load_eff] <= element_value;
        end
    end

    // Select divider operands: raster split first, ring modulo second
    assign div_start    = cmd.read_start | cmd.mod_start;
    assign div_dividend = cmd.read_start ? SUM_W'(read_eff)
                                         : SUM_W'(p_reg) + SUM_W'(rotate_steps_reg);
    assign div_divisor  = cmd.read_start ? LEN_W'(m_eff) : len_reg;

    mrr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Find the ring and the position along it
    always_comb
    begin
        i_v    = RING_W'(div_quo[IDX_W-1:0]);
        j_v    = RING_W'(div_rem[IDX_W-1:0]);
        n_v    = RING_W'(n_eff);
        m_v    = RING_W'(m_eff);
        ri_v   = n_v - 1'b1 - i_v;
        cj_v   = m_v - 1'b1 - j_v;
        k_v    = (i_v < j_v) ? i_v : j_v;
        if (ri_v < k_v)
        begin
            k_v = ri_v;
        end
        if (cj_v < k_v)
        begin
            k_v = cj_v;
        end
        half_v    = ((n_v < m_v) ? n_v : m_v) >> 1;
        in_ring_v = (k_v < half_v);
        w_v    = m_v - (k_v << 1);
        h_v    = n_v - (k_v << 1);
        len_v  = (w_v << 1) + (h_v << 1) - RING_W'(4);
        b1_v   = w_v + h_v - RING_W'(2);
        b2_v   = (w_v << 1) + h_v - RING_W'(3);
        if (i_v == k_v)
        begin
            p_v = j_v - k_v;
        end
        else if ((j_v == m_v - 1'b1 - k_v) && (i_v < n_v - 1'b1 - k_v))
        begin
            p_v = w_v + i_v - k_v - 1'b1;
        end
        else if ((i_v == n_v - 1'b1 - k_v) && (j_v > k_v))
        begin
            p_v = b1_v + (m_v - 1'b1 - k_v - j_v);
        end
        else
        begin
            p_v = b2_v + (n_v - 1'b1 - k_v - i_v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_start)
        begin
            rpos_reg <= read_eff;
        end
        if (cmd.ring_latch)
        begin
            k_reg       <= k_v;
            w_reg       <= w_v;
            b1_reg      <= b1_v;
            b2_reg      <= b2_v;
            p_reg       <= p_v;
            len_reg     <= len_v[LEN_W-1:0];
            in_ring_reg <= in_ring_v;
            row_end_reg <= (j_v == m_v - 1'b1);
            mat_end_reg <= ({1'b0, rpos_reg} == total - 1'b1);
        end
    end

    // Map the rotated ring position back to a row and column
    always_comb
    begin
        q_v      = RING_W'(div_rem);
        last_r_v = RING_W'(n_eff) - 1'b1 - k_reg;
        last_c_v = RING_W'(m_eff) - 1'b1 - k_reg;
        if (q_v < w_reg)
        begin
            sr_v = k_reg;
            sc_v = k_reg + q_v;
        end
        else if (q_v < b1_reg)
        begin
            sr_v = k_reg + 1'b1 + (q_v - w_reg);
            sc_v = last_c_v;
        end
        else if (q_v < b2_reg)
        begin
            sr_v = last_r_v;
            sc_v = last_c_v - (q_v - b1_reg);
        end
        else
        begin
            sr_v = last_r_v - (q_v - b2_reg);
            sc_v = k_reg;
        end
        src_prod  = (POS_W+1)'(sr_v[IDX_W-1:0] * m_eff) + (POS_W+1)'(sc_v[IDX_W-1:0]);
        addr_next = in_ring_reg ? src_prod[POS_W-1:0] : rpos_reg;
    end

    // Register the source address, then read the store
    always_ff @(posedge clk)
    begin
        if (cmd.addr_latch)
        begin
            addr_reg <= addr_next;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= store_mem[addr_reg];
        end
    end

    // Output register: load a word, drop it once taken
    assign out_take = out_valid_reg & ~out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rot_reg         <= rdata_reg;
            row_end_out_reg <= row_end_reg;
            mat_end_out_reg <= mat_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_free = ~out_valid_reg | ~out_stall;

    assign out_valid     = out_valid_reg;
    assign rotated_value = rot_reg;
    assign row_end       = row_end_out_reg;
    assign matrix_end    = mat_end_out_reg;

endmodule

// ===== rtl/mrr_ctrl.sv =====
// Controller of the matrix ring rotator: issues load writes and sequences one read
// word through split, ring lookup, modulo, address, store read and output load.
// Depends on mrr_pkg.
module mrr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 action,
    output logic                 in_stall,
    input  mrr_pkg::mrr_status_t status,
    output mrr_pkg::mrr_cmd_t    cmd
);
    import mrr_pkg::*;

    mrr_state_t state_reg;
    mrr_state_t state_next;
    logic       accept;

    assign accept = in_valid & (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_READ))
                begin
                    state_next = ST_DIV_POS;
                end
            end
            ST_DIV_POS:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_RING;
                end
            end
            ST_RING:    state_next = ST_MOD_GO;
            ST_MOD_GO:  state_next = ST_DIV_MOD;
            ST_DIV_MOD:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:    state_next = ST_MEM;
            ST_MEM:     state_next = ST_OUT;
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_we    = accept & (action == ACT_LOAD);
                cmd.read_start = accept & (action == ACT_READ);
            end
            ST_RING:    cmd.ring_latch = 1'b1;
            ST_MOD_GO:  cmd.mod_start  = 1'b1;
            ST_DIV_MOD: cmd.addr_latch = ~status.div_busy;
            ST_MEM:     cmd.mem_rd     = 1'b1;
            ST_OUT:     cmd.out_load   = status.out_free;
            default:    ;
        endcase
    end

endmodule

// ===== rtl/matrix_ring_rotate.sv =====
// Top level of the matrix ring rotator: controller plus datapath.
// Depends on mrr_pkg, mrr_ctrl and mrr_datapath.
//
// Load words (action 0) fill a row_count by col_count matrix in raster order;
// one is taken per clock while no read is in progress. Read words (action 1)
// return the matrix in raster order with every concentric ring turned
// counterclockwise by rotate_steps places; each read goes from acceptance to
// the result word loaded into the output register through two passes of one
// shared 3-bit-per-cycle divider (position over cols, then ring position plus
// steps modulo ring length) plus ring, address and store read steps. One read
// is in flight at a time; the result register lets the next word enter while
// a result waits. Dimensions clamp to 2..64; write configuration only while
// the block is idle. Reading an entry that was never loaded returns undefined
// data.
module matrix_ring_rotate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic signed [mrr_pkg::DATA_WIDTH-1:0] element_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mrr_pkg::DATA_WIDTH-1:0] rotated_value,
    output logic                                  row_end,
    output logic                                  matrix_end,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mrr_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mrr_pkg::*;

    mrr_cmd_t    cmd;
    mrr_status_t status;

    // Configuration writes are always accepted; cfg_ready is tied high
    assign cfg_ready = 1'b1;

    mrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mrr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_value (element_value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .rotated_value (rotated_value),
        .row_end       (row_end),
        .matrix_end    (matrix_end)
    );

endmodule
